/* hw/rtl/bdpc_pkg.sv */
// Shared types and constants for the button debounce press classifier.
// Depends on nothing; imported by bdpc_lane, bdpc_merge and the top level.
package bdpc_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DEB_W      = 8;
  localparam int unsigned CNT_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd3;
  localparam logic [CNT_W-1:0] LONG_RESET     = 16'd80;
  localparam logic [CNT_W-1:0] HOLD_RESET     = 16'd300;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2,
    EV_HOLD  = 2'd3
  } event_e;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] long_ticks;
    logic [CNT_W-1:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    event_e ev0;
    event_e ev1;
  } result_t;

endpackage

/* hw/rtl/bdpc_lane.sv */
// One button lane: debounce, press timing and short/long/hold classification.
// Depends on bdpc_pkg.
module bdpc_lane (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            raw_pressed_i,
  input  bdpc_pkg::cfg_t  cfg_i,
  output bdpc_pkg::event_e ev_o
);
  import bdpc_pkg::*;

  logic             last_raw_q, last_raw_d;
  logic [DEB_W-1:0] stable_q, stable_d;
  logic             conf_q, conf_d;
  logic             active_q, active_d;
  logic [CNT_W-1:0] elapsed_q, elapsed_d;
  logic             hold_q, hold_d;
  event_e           ev;

  always_comb begin
    last_raw_d = last_raw_q;
    stable_d   = stable_q;
    conf_d     = conf_q;
    active_d   = active_q;
    hold_d     = hold_q;
    ev         = EV_NONE;
    elapsed_d  = (active_q && (elapsed_q != {CNT_W{1'b1}})) ? elapsed_q + 16'd1 : elapsed_q;

    if (raw_pressed_i != last_raw_q) begin
      last_raw_d = raw_pressed_i;
      stable_d   = '0;
    end else begin
      if (stable_q != {DEB_W{1'b1}}) stable_d = stable_q + 8'd1;
      if ((stable_d >= cfg_i.debounce_ticks) && (conf_q != raw_pressed_i)) begin
        conf_d = raw_pressed_i;
        if (raw_pressed_i) begin
          active_d  = 1'b1;
          elapsed_d = '0;
          hold_d    = 1'b0;
        end else begin
          if (active_q && !hold_q) begin
            ev = (elapsed_d >= cfg_i.long_ticks) ? EV_LONG : EV_SHORT;
          end
          active_d  = 1'b0;
          elapsed_d = '0;
        end
      end
    end

    // fire hold once per press
    if (conf_d && active_d && !hold_d && (elapsed_d >= cfg_i.hold_ticks)) begin
      hold_d = 1'b1;
      ev     = EV_HOLD;
    end
  end

  assign ev_o = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      stable_q   <= '0;
      conf_q     <= 1'b0;
      active_q   <= 1'b0;
      elapsed_q  <= '0;
      hold_q     <= 1'b0;
    end else if (en_i) begin
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      conf_q     <= conf_d;
      active_q   <= active_d;
      elapsed_q  <= elapsed_d;
      hold_q     <= hold_d;
    end
  end

endmodule

/* hw/rtl/bdpc_merge.sv */
// Merge stage: gathers lane events into one result, output register plus skid.
// Depends on bdpc_pkg.
module bdpc_merge #(
  parameter int unsigned NUM_BUTTONS = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  bdpc_pkg::event_e  lane_ev_i [NUM_BUTTONS],
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic              skid_full_o,
  output bdpc_pkg::result_t result_o
);
  import bdpc_pkg::*;

  result_t merged;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    out_fire;

  // lanes without an output field are dropped; a missing lane reads as none
  if (NUM_BUTTONS > 1) begin : g_two
    assign merged = '{ev0: lane_ev_i[0], ev1: lane_ev_i[1]};
  end else begin : g_one
    assign merged = '{ev0: lane_ev_i[0], ev1: EV_NONE};
  end

  assign out_fire = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (accept_i) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (out_valid_q && !out_fire) skid_q <= merged;
      else                          out_q  <= merged;
    end else if (out_fire && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign skid_full_o = skid_valid_q;
  assign result_o    = out_q;

endmodule

/* hw/rtl/button_debounce_press_classifier.sv */
// Top level of the button debounce press classifier: config registers, lanes, merge.
// Depends on bdpc_pkg, bdpc_lane and bdpc_merge.
//
// Usage:
//   Input channel: one transaction per poll tick, pin_levels_i bit i is the
//   active-low pin of button i. Accepted when in_valid_i is high and
//   in_stall_o is low.
//   Output channel: one transaction per input transaction, one 2-bit event
//   per button (none, short, long, hold). Taken when out_valid_o is high and
//   out_stall_i is low.
//   Config channel: cfg_valid_i with cfg_index_i/cfg_data_i; always ready.
//   Index 0 debounce ticks, 1 long threshold, 2 hold threshold; others ignored.
// Throughput: one item per cycle while in_stall_o is low; the result is registered
//   in the output register, or in the skid while the output register is stalled.
// Stall: a two-entry output buffer (register plus skid) absorbs one extra
//   transaction; in_stall_o rises only once both entries are full.
// Reset: all lanes clear to released and idle, thresholds return to
//   3 / 80 / 300 ticks, the output buffer empties.
module button_debounce_press_classifier #(
  parameter int unsigned NUM_BUTTONS = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         pin_levels_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         event_button0_o,
  output logic [1:0]                         event_button1_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import bdpc_pkg::*;

  cfg_t    cfg_q;
  logic    accept;
  logic    skid_full;
  event_e  lane_ev [NUM_BUTTONS];
  result_t result;

  assign cfg_ready_o = 1'b1;

  // Hold thresholds; write only the addressed register, drop unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= DEBOUNCE_RESET;
      cfg_q.long_ticks     <= LONG_RESET;
      cfg_q.hold_ticks     <= HOLD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data_i[DEB_W-1:0];
        CFG_LONG:     cfg_q.long_ticks     <= cfg_data_i;
        CFG_HOLD:     cfg_q.hold_ticks     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_full;
  assign accept     = in_valid_i && !skid_full;

  // One lane per button; buttons beyond the pin field see a pressed level.
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic raw_pressed;
    if (b < 2) begin : g_pin
      assign raw_pressed = ~pin_levels_i[b];
    end else begin : g_nopin
      assign raw_pressed = 1'b1;
    end

    bdpc_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (accept),
      .raw_pressed_i (raw_pressed),
      .cfg_i         (cfg_q),
      .ev_o          (lane_ev[b])
    );
  end

  bdpc_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .lane_ev_i   (lane_ev),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .skid_full_o (skid_full),
    .result_o    (result)
  );

  assign event_button0_o = result.ev0;
  assign event_button1_o = result.ev1;

endmodule

/* hw/rtl/bdpc_checker.sv */
// Port-level checker for the button debounce press classifier, bound to the top.
// Depends on button_debounce_press_classifier ports only.
module bdpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] event_button0_o,
  input logic [1:0] event_button1_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(event_button0_o) && $stable(event_button1_o))
    else $error("stalled output transaction changed or dropped");

  // input stalls only while a result is pending
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // stall rises only after the output was blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output backpressure");

  // an accepted item into an empty buffer shows up next cycle
  a_result_appears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .event_button0_o (event_button0_o),
  .event_button1_o (event_button1_o)
);
